// File: sv/dpaf_pkg.sv
`default_nettype none

package dpaf_pkg;

    localparam int NUM_STUDIOS = 8;
    localparam int NUM_CH      = 9;
    localparam int DEPTH       = NUM_STUDIOS * NUM_CH;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CH_W        = $clog2(NUM_CH + 1);
    localparam int STUDIO_W    = 3;
    localparam int MODE_W      = 2;
    localparam int CTRL_W      = 16;
    localparam int SUM_W       = 24;
    localparam int DELTA_W     = 16;
    localparam int FADE_W      = 6;
    localparam int IN_W        = 168;
    localparam int OUT_W       = 40;

    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FADE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [CTRL_W-1:0] CTRL_MAIN_SUR = 16'h0004;
    localparam logic [CTRL_W-1:0] CTRL_AUXA     = 16'h0001;
    localparam logic [CTRL_W-1:0] CTRL_AUXA_SUR = 16'h0014;
    localparam logic [CTRL_W-1:0] CTRL_AUXB     = 16'h0012;
    localparam logic [CTRL_W-1:0] CTRL_AUXB_SUR = 16'h0004;

    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [DELTA_W-1:0] delta_t;
    typedef logic signed [FADE_W-1:0]  fade_t;

    localparam sum_t SUM_MAX  = 24'sh7fffff;
    localparam sum_t SUM_MIN  = -24'sh7fffff;
    localparam sum_t FADE_SAT = 24'sd3200;
    localparam logic [4:0] FADE_LIMIT = 5'd20;
    localparam logic [7:0] RECIP_5    = 8'd205;

    function automatic logic [ADDR_W-1:0] entry_addr(input logic [STUDIO_W-1:0] studio,
                                                   input logic [CH_W-1:0] ch);
        logic [ADDR_W+STUDIO_W+CH_W-1:0] a;
        a = (ADDR_W+STUDIO_W+CH_W)'(studio) * (ADDR_W+STUDIO_W+CH_W)'(NUM_CH)
            + (ADDR_W+STUDIO_W+CH_W)'(ch);
        return a[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/depop_accumulator_fade_unit.sv
// Output: fade results leave one per cycle, stalling while m_tready is low.
// Items: 9 channel read-modify-writes per accepted item through the sum RAM's
//   one read and one write port; no new item is taken until the last channel
//   is written. Unused mode or studio out of range: accepted and dropped.
// Reset: rst_n clears control and the per-entry valid bits; all sums read as zero.
`default_nettype none

module depop_accumulator_fade_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // mode[1:0], studio[4:2], mixer_ctrl[20:5], nine 16-bit deltas [164:21], zero pad
    input  wire logic [dpaf_pkg::IN_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // channel[3:0], start_value[27:4], fade_delta[33:28], zero pad
    output logic [dpaf_pkg::OUT_W-1:0]     m_tdata,
    output logic                           m_tlast
);

    import dpaf_pkg::*;

    logic                busy_reg, busy_next;
    logic [MODE_W-1:0]   mode_reg;
    logic [STUDIO_W-1:0] studio_reg;
    logic [CTRL_W-1:0]   ctrl_reg;
    delta_t              deltas_reg [NUM_CH];
    logic [CH_W-1:0]     issue_ch_reg, issue_ch_next;
    logic                p_vld_reg, p_vld_next;
    logic [CH_W-1:0]     p_ch_reg;
    logic                rd_ok_reg;
    logic [DEPTH-1:0]    valid_reg, valid_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]    m_tdata_reg;
    logic                m_tlast_reg;

    logic                accept, start, in_range;
    logic                out_free, p_go, adv, issue;
    logic [ADDR_W-1:0]   raddr, waddr;
    logic [SUM_W-1:0]    rdata;
    sum_t                cur_sum, new_sum;
    fade_t               fade_delta;
    logic                apply;
    logic                load_out;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    assign in_range = int'(s_tdata[4:2]) < NUM_STUDIOS;
    assign start    = accept && in_range
                      && (s_tdata[1:0] == MODE_ADD || s_tdata[1:0] == MODE_FADE
                          || s_tdata[1:0] == MODE_CLEAR);

    assign out_free = !m_tvalid_reg || m_tready;
    assign p_go     = p_vld_reg && (mode_reg != MODE_FADE || out_free);
    assign adv      = !p_vld_reg || p_go;
    assign issue    = busy_reg && (issue_ch_reg != CH_W'(NUM_CH)) && adv;
    assign load_out = p_go && (mode_reg == MODE_FADE);

    assign raddr   = entry_addr(studio_reg, issue_ch_reg);
    assign waddr   = entry_addr(studio_reg, p_ch_reg);
    assign cur_sum = rd_ok_reg ? sum_t'(rdata) : '0;

    always_comb
    begin
        unique case (p_ch_reg)
            4'd0, 4'd1: apply = 1'b1;
            4'd2:       apply = |(ctrl_reg & CTRL_MAIN_SUR);
            4'd3, 4'd4: apply = |(ctrl_reg & CTRL_AUXA);
            4'd5:       apply = |(ctrl_reg & CTRL_AUXA) && |(ctrl_reg & CTRL_AUXA_SUR);
            4'd6, 4'd7: apply = |(ctrl_reg & CTRL_AUXB);
            4'd8:       apply = |(ctrl_reg & CTRL_AUXB) && |(ctrl_reg & CTRL_AUXB_SUR);
            default:    apply = 1'b0;
        endcase
    end

    dpaf_ram #(
        .DATA_W (SUM_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_sums (
        .clk   (clk),
        .we    (p_go),
        .waddr (waddr),
        .wdata (new_sum),
        .re    (issue),
        .raddr (raddr),
        .rdata (rdata)
    );

    dpaf_chan_alu u_alu (
        .mode       (mode_reg),
        .apply      (apply),
        .sum        (cur_sum),
        .delta      (deltas_reg[p_ch_reg]),
        .new_sum    (new_sum),
        .fade_delta (fade_delta)
    );

    always_comb
    begin
        busy_next     = busy_reg;
        issue_ch_next = issue_ch_reg;
        p_vld_next    = p_vld_reg;
        valid_next    = valid_reg;
        m_tvalid_next = m_tvalid_reg;

        if (start)
        begin
            busy_next     = 1'b1;
            issue_ch_next = '0;
        end
        else if (issue)
        begin
            issue_ch_next = issue_ch_reg + 1'b1;
        end

        if (issue)
        begin
            p_vld_next = 1'b1;
        end
        else if (p_go)
        begin
            p_vld_next = 1'b0;
        end

        if (p_go)
        begin
            valid_next[waddr] = 1'b1;
            if (p_ch_reg == CH_W'(NUM_CH - 1))
            begin
                busy_next = 1'b0;
            end
        end

        if (load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            issue_ch_reg <= '0;
            p_vld_reg    <= 1'b0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            issue_ch_reg <= issue_ch_next;
            p_vld_reg    <= p_vld_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= s_tdata[1:0];
            studio_reg <= s_tdata[4:2];
            ctrl_reg   <= s_tdata[20:5];
            for (int i = 0; i < NUM_CH; i++)
            begin
                deltas_reg[i] <= s_tdata[21 + i*DELTA_W +: DELTA_W];
            end
        end
        if (issue)
        begin
            p_ch_reg  <= issue_ch_reg;
            rd_ok_reg <= valid_reg[raddr];
        end
        if (load_out)
        begin
            m_tdata_reg <= {6'd0, fade_delta, cur_sum, p_ch_reg};
            m_tlast_reg <= p_ch_reg == CH_W'(NUM_CH - 1);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// File: sv/dpaf_ram.sv
`default_nettype none

module dpaf_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 72,
    parameter int ADDR_W = 7
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/dpaf_chan_alu.sv
`default_nettype none

module dpaf_chan_alu (
    input  wire logic [dpaf_pkg::MODE_W-1:0] mode,
    input  wire logic                        apply,
    input  wire dpaf_pkg::sum_t              sum,
    input  wire dpaf_pkg::delta_t            delta,
    output dpaf_pkg::sum_t                   new_sum,
    output dpaf_pkg::fade_t                  fade_delta
);

    import dpaf_pkg::*;

    logic signed [SUM_W:0] add_wide;
    logic signed [SUM_W:0] fade_wide;
    logic signed [SUM_W:0] fade_ext;
    sum_t                  sat_sum;
    sum_t                  abs_s;
    logic                  big;
    logic [6:0]            coarse;
    logic [14:0]           prod;
    logic [4:0]            mag;

    // saturating add of one voice delta
    always_comb
    begin
        add_wide = (SUM_W+1)'(sum) + (SUM_W+1)'(delta);
        if (add_wide > (SUM_W+1)'(SUM_MAX))
        begin
            sat_sum = SUM_MAX;
        end
        else if (add_wide < (SUM_W+1)'(SUM_MIN))
        begin
            sat_sum = SUM_MIN;
        end
        else
        begin
            sat_sum = add_wide[SUM_W-1:0];
        end
    end

    // |s|/160 = floor(floor(|s|/32)/5), /5 by reciprocal 205/1024
    always_comb
    begin
        abs_s  = sum[SUM_W-1] ? -sum : sum;
        big    = abs_s >= FADE_SAT;
        coarse = abs_s[11:5];
        prod   = 15'(coarse) * 15'(RECIP_5);
        mag    = big ? FADE_LIMIT : prod[14:10];
        fade_delta = sum[SUM_W-1] ? fade_t'({1'b0, mag}) : -fade_t'({1'b0, mag});
    end

    always_comb
    begin
        fade_ext  = (SUM_W+1)'(fade_delta);
        fade_wide = (SUM_W+1)'(sum) + (fade_ext <<< 7) + (fade_ext <<< 5);
    end

    always_comb
    begin
        unique case (mode)
            MODE_ADD:   new_sum = apply ? sat_sum : sum;
            MODE_FADE:  new_sum = fade_wide[SUM_W-1:0];
            MODE_CLEAR: new_sum = '0;
            default:    new_sum = sum;
        endcase
    end

endmodule

`default_nettype wire

// File: bench/depop_fade_checker.sv
module depop_fade_checker
    import dpaf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    input  logic             m_tlast,
    input  logic             finish_req,
    output int               errors,
    output int               pending_beats,
    output int               results_seen,
    output int               clamps_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DELTA_LSB  = MODE_W + STUDIO_W + CTRL_W;
    localparam int FADE_UNIT  = 160;
    localparam int FADE_STEPS = 20;

    typedef struct {
        logic [3:0] ch;
        sum_t       start;
        fade_t      fade;
        logic       last;
    } fade_beat_t;

    sum_t       depop_sum [DEPTH];
    fade_beat_t fade_beats_due [$];
    bit         leftover_checked;

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    function automatic fade_t fade_of(input sum_t s);
        int v;
        v = int'(s);
        if (v <= -FADE_UNIT * FADE_STEPS)
            return fade_t'(FADE_STEPS);
        if (v <= -FADE_UNIT)
            return fade_t'((-v) / FADE_UNIT);
        if (v < FADE_UNIT)
            return '0;
        if (v < FADE_UNIT * FADE_STEPS)
            return fade_t'((-v) / FADE_UNIT);
        return fade_t'(-FADE_STEPS);
    endfunction

    task automatic bump(input int idx, input delta_t d);
        int t;
        t = int'(depop_sum[idx]) + int'(d);
        if (t > int'(SUM_MAX))
        begin
            t = int'(SUM_MAX);
            clamps_seen++;
        end
        else if (t < int'(SUM_MIN))
        begin
            t = int'(SUM_MIN);
            clamps_seen++;
        end
        depop_sum[idx] = sum_t'(t);
    endtask

    function automatic delta_t voice_delta(input logic [IN_W-1:0] beat, input int k);
        return beat[DELTA_LSB + DELTA_W*k +: DELTA_W];
    endfunction

    task automatic apply_voice_deltas(input int base, input logic [IN_W-1:0] beat);
        logic [CTRL_W-1:0] ctrl;
        ctrl = beat[MODE_W+STUDIO_W +: CTRL_W];
        bump(base + 0, voice_delta(beat, 0));
        bump(base + 1, voice_delta(beat, 1));
        if ((ctrl & CTRL_MAIN_SUR) != 0)
            bump(base + 2, voice_delta(beat, 2));
        if ((ctrl & CTRL_AUXA) != 0)
        begin
            bump(base + 3, voice_delta(beat, 3));
            bump(base + 4, voice_delta(beat, 4));
            if ((ctrl & CTRL_AUXA_SUR) != 0)
                bump(base + 5, voice_delta(beat, 5));
        end
        if ((ctrl & CTRL_AUXB) != 0)
        begin
            bump(base + 6, voice_delta(beat, 6));
            bump(base + 7, voice_delta(beat, 7));
            if ((ctrl & CTRL_AUXB_SUR) != 0)
                bump(base + 8, voice_delta(beat, 8));
        end
    endtask

    task automatic run_fade_step(input int base);
        fade_beat_t b;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            b.ch    = 4'(ch);
            b.start = depop_sum[base + ch];
            b.fade  = fade_of(b.start);
            b.last  = (ch == NUM_CH - 1);
            fade_beats_due.push_back(b);
            depop_sum[base + ch] = sum_t'(int'(b.start) + int'(b.fade) * FADE_UNIT);
        end
    endtask

    task automatic check_result();
        fade_beat_t due;
        logic [3:0] got_ch;
        sum_t       got_start;
        fade_t      got_fade;
        got_ch    = m_tdata[3:0];
        got_start = m_tdata[27:4];
        got_fade  = m_tdata[33:28];
        results_seen++;
        if (fade_beats_due.size() == 0)
        begin
            report($sformatf("result beat ch %0d with nothing expected", got_ch));
            return;
        end
        due = fade_beats_due.pop_front();
        if (got_ch !== due.ch)
            report($sformatf("channel %0d, expected %0d", got_ch, due.ch));
        if (got_start !== due.start)
            report($sformatf("ch %0d start %0d, expected %0d", due.ch, got_start, due.start));
        if (got_fade !== due.fade)
            report($sformatf("ch %0d fade %0d, expected %0d", due.ch, got_fade, due.fade));
        if (m_tlast !== due.last)
            report($sformatf("ch %0d tlast %b, expected %b", due.ch, m_tlast, due.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (depop_sum[i])
                depop_sum[i] = '0;
            fade_beats_due.delete();
            errors           = 0;
            results_seen     = 0;
            clamps_seen      = 0;
            leftover_checked = 0;
            pending_beats   <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
            begin
                logic [STUDIO_W-1:0] studio;
                int base;
                studio = s_tdata[MODE_W +: STUDIO_W];
                base   = int'(studio) * NUM_CH;
                if (int'(studio) < NUM_STUDIOS)
                begin
                    case (s_tdata[MODE_W-1:0])
                        MODE_ADD:   apply_voice_deltas(base, s_tdata);
                        MODE_FADE:  run_fade_step(base);
                        MODE_CLEAR:
                            for (int ch = 0; ch < NUM_CH; ch++)
                                depop_sum[base + ch] = '0;
                        default: ;
                    endcase
                end
            end
            if (finish_req && !leftover_checked)
            begin
                leftover_checked = 1;
                if (fade_beats_due.size() != 0)
                    report($sformatf("%0d result beats never arrived", fade_beats_due.size()));
            end
            pending_beats <= fade_beats_due.size();
        end
    end

endmodule

// File: bench/depop_accumulator_fade_unit_test.sv
module depop_accumulator_fade_unit_test;
    import dpaf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 30;
    localparam int RANDOM_ITEMS = 36;
    localparam int SAT_ROUNDS   = 260;
    localparam int FIELDS_W     = MODE_W + STUDIO_W + CTRL_W + NUM_CH * DELTA_W;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef logic [NUM_CH-1:0][DELTA_W-1:0] delta_set_t;
    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_SPELLS} rx_style_t;

    logic             clk;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             s_tready;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;
    logic             drain_done = 1'b0;

    int        errors, pending_beats, results_seen, clamps_seen;
    int        idle_cycles = 0;
    int        hold_req    = 0;
    rx_style_t rx_style    = RX_RANDOM;
    bit        no_gaps     = 0;
    int        burst_left  = 0;
    int        n_add, n_fade, n_clear, n_unused;
    int        pick [NUM_CH];

    depop_accumulator_fade_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    depop_fade_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .finish_req    (drain_done),
        .errors        (errors),
        .pending_beats (pending_beats),
        .results_seen  (results_seen),
        .clamps_seen   (clamps_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("FAIL depop_accumulator_fade_unit");
        $finish;
    end

    // output side: style set by stimulus, plus long hold-offs on request
    initial
    begin
        int hold_left, hold_taken, spell_left, cyc;
        hold_left  = 0;
        hold_taken = 0;
        spell_left = 0;
        cyc        = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_left == 0 && hold_taken != hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_taken++;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                case (rx_style)
                    RX_ALWAYS:   m_tready <= 1'b1;
                    RX_RANDOM:   m_tready <= ($urandom_range(0, 99) < 65);
                    RX_PERIODIC: m_tready <= ((cyc % 7) >= 3);
                    default:
                    begin
                        if (spell_left == 0 && $urandom_range(0, 99) < 5)
                            spell_left = $urandom_range(4, 24);
                        m_tready <= (spell_left == 0);
                        if (spell_left > 0)
                            spell_left--;
                    end
                endcase
            end
        end
    end

    function automatic delta_set_t uniform(input logic [DELTA_W-1:0] v);
        delta_set_t d;
        for (int k = 0; k < NUM_CH; k++)
            d[k] = v;
        return d;
    endfunction

    function automatic delta_set_t from_pick();
        delta_set_t d;
        for (int k = 0; k < NUM_CH; k++)
            d[k] = DELTA_W'(pick[k]);
        return d;
    endfunction

    function automatic delta_set_t random_deltas();
        delta_set_t d;
        int r;
        for (int k = 0; k < NUM_CH; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
                d[k] = DELTA_W'($urandom);
            else if (r < 50)
                d[k] = DELTA_W'($signed($urandom_range(0, 800)) - 400);
            else if (r < 65)
                case ($urandom_range(0, 3))
                    0: d[k] = 16'h8000;
                    1: d[k] = 16'h7fff;
                    2: d[k] = 16'h0000;
                    default: d[k] = 16'hffff;
                endcase
            else
                d[k] = DELTA_W'($signed($urandom_range(0, 10000)) - 5000);
        end
        return d;
    endfunction

    function automatic logic [CTRL_W-1:0] random_ctrl();
        logic [CTRL_W-1:0] c;
        c = CTRL_W'($urandom_range(0, 31));
        if ($urandom_range(0, 1) == 1)
            c = c | (CTRL_W'($urandom) & 16'hffe0);
        return c;
    endfunction

    function automatic logic [MODE_W-1:0] random_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return MODE_ADD;
        if (r < 80)
            return MODE_FADE;
        if (r < 92)
            return MODE_CLEAR;
        return MODE_UNUSED;
    endfunction

    function automatic logic [STUDIO_W-1:0] random_studio();
        if ($urandom_range(0, 99) < 70)
            return STUDIO_W'($urandom_range(0, 3));
        return STUDIO_W'($urandom_range(4, 7));
    endfunction

    task automatic send_item(input logic [MODE_W-1:0] mode, input int studio,
                             input logic [CTRL_W-1:0] ctrl, input delta_set_t d);
        logic [IN_W-1:0] beat;
        int gap;
        beat = '0;
        beat[FIELDS_W-1:0] = {d, ctrl, STUDIO_W'(studio), mode};
        case (mode)
            MODE_ADD:   n_add++;
            MODE_FADE:  n_fade++;
            MODE_CLEAR: n_clear++;
            default:    n_unused++;
        endcase
        if (burst_left == 0)
        begin
            gap = no_gaps ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tdata  <= beat;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_beats != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int fades_left;
        logic [MODE_W-1:0] mode;
        fades_left = 0;
        n_add = 0;
        n_fade = 0;
        n_clear = 0;
        n_unused = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fresh sums, fade boundaries, mask gating, clear, unused mode
        send_item(MODE_FADE, 0, 16'h0000, uniform(16'h0000));
        pick = '{-3200, -3199, -161, -160, -159, 159, 160, 161, 3199};
        send_item(MODE_ADD, 1, 16'hffff, from_pick());
        send_item(MODE_FADE, 1, 16'h0000, uniform(16'h0000));
        send_item(MODE_FADE, 1, 16'h0000, uniform(16'h0000));
        pick = '{3200, 3201, -3201, 32767, -32768, 319, -319, 1, -1};
        send_item(MODE_ADD, 2, 16'hffff, from_pick());
        send_item(MODE_FADE, 2, 16'h0000, uniform(16'h0000));
        pick = '{16'h0000, 16'h0004, 16'h0001, 16'h0005, 16'h0011,
                 16'h0010, 16'h0002, 16'h0006, 16'hffe8};
        for (int k = 0; k < NUM_CH; k++)
            send_item(MODE_ADD, 3, CTRL_W'(pick[k]), uniform(DELTA_W'(1 << k)));
        send_item(MODE_FADE, 3, 16'h0000, uniform(16'h0000));
        send_item(MODE_CLEAR, 1, 16'hffff, uniform(16'hffff));
        send_item(MODE_FADE, 1, 16'h0000, uniform(16'h0000));
        send_item(MODE_UNUSED, 2, 16'hffff, uniform(16'h5555));
        send_item(MODE_FADE, 2, 16'h0000, uniform(16'h0000));
        send_item(MODE_ADD, 7, 16'haaaa, uniform(16'h5555));
        send_item(MODE_ADD, 7, 16'h5555, uniform(16'haaaa));
        send_item(MODE_FADE, 7, 16'h0000, uniform(16'h0000));
        send_item(MODE_CLEAR, 7, 16'h0000, uniform(16'h0000));
        send_item(MODE_ADD, 4, 16'hffff, uniform(16'h8000));
        send_item(MODE_FADE, 4, 16'h0000, uniform(16'h0000));

        // drive one studio into the upper clamp
        rx_style <= RX_PERIODIC;
        for (int r = 0; r < SAT_ROUNDS; r++)
        begin
            send_item(MODE_ADD, 7, 16'hffff,
                      uniform(DELTA_W'($urandom_range(32700, 32767))));
            if (r % 45 == 44)
                send_item(MODE_FADE, 7, 16'h0000, uniform(16'h0000));
        end
        send_item(MODE_FADE, 7, 16'h0000, uniform(16'h0000));
        send_item(MODE_ADD, 7, 16'hffff, uniform(16'h8000));
        send_item(MODE_ADD, 6, 16'hffff, uniform(16'h7fff));
        send_item(MODE_FADE, 7, 16'h0000, uniform(16'h0000));
        send_item(MODE_FADE, 6, 16'h0000, uniform(16'h0000));

        rx_style <= RX_ALWAYS;
        no_gaps = 1;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 5)
            begin
                no_gaps = 0;
                rx_style <= RX_RANDOM;
            end
            if (i == 8)
            begin
                hold_req <= hold_req + 1;
                no_gaps = 1;
                fades_left = 12;
            end
            if (i == 20)
                no_gaps = 0;
            if (i == 23)
                rx_style <= RX_PERIODIC;
            if (i == 27)
                wait_drained();
            if (i == 30)
                rx_style <= RX_SPELLS;
            if (fades_left > 0)
            begin
                mode = MODE_FADE;
                fades_left--;
            end
            else
                mode = random_mode();
            send_item(mode, random_studio(), random_ctrl(), random_deltas());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        drain_done <= 1'b1;
        repeat (2) @(posedge clk);
        $display("covered %0d add, %0d fade, %0d clear and %0d unused-mode beats on 8 studios",
                 n_add, n_fade, n_clear, n_unused);
        $display("checked %0d fade result beats; %0d clamped additions; one long output hold",
                 results_seen, clamps_seen);
        if (errors == 0)
            $display("PASS depop_accumulator_fade_unit");
        else
            $display("FAIL depop_accumulator_fade_unit");
        $finish;
    end

endmodule
